// ----- hw/rtl/amss_pkg.sv -----
// Shared types and constants for the ADC mux scan sequencer.
package amss_pkg;

  localparam int ACTION_W  = 2;
  localparam int CHAN_W    = 3;
  localparam int SAMPLE_W  = 6;
  localparam int STATUS_W  = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SELECT   = 2'd0,
    ACT_DESELECT = 2'd1,
    ACT_SAMPLE   = 2'd2,
    ACT_READ     = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_NOT_SEL = 2'd2
  } status_t;

  // Result word held in the output register, apart from the channel number.
  typedef struct packed {
    status_t status;
    logic    adc_enable;
    logic    read_ok;
  } result_t;

endpackage

// ----- hw/rtl/amss_store.sv -----
// Sample store: one-write, one-read synchronous memory with registered read data.
module amss_store
  import amss_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int DW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/amss_ctrl.sv -----
// Scan control: channel mask, mux pointer, action decode and result register.
module amss_ctrl
  import amss_pkg::*;
#(
  parameter int CHANNELS = 8,
  parameter int CH_W     = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [CHAN_W-1:0]   in_channel,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output result_t             result,
  output logic [CH_W-1:0]     cur_chan,
  output logic                mem_we,
  output logic [CH_W-1:0]     mem_waddr,
  output logic [SAMPLE_W-1:0] mem_wdata,
  output logic                mem_re,
  output logic [CH_W-1:0]     mem_raddr
);

  logic [CHANNELS-1:0] mask_r, mask_nxt;
  logic [CH_W-1:0]     cur_r, cur_nxt;
  logic                valid_r, valid_nxt;
  result_t             result_r, result_nxt;

  logic                accept;
  logic                ch_in_range;
  logic [CH_W-1:0]     ch_idx;
  logic                ch_on;
  logic                cur_on;
  logic [CH_W-1:0]     next_chan;
  logic [CH_W:0]       cand;

  assign in_stall    = valid_r && out_stall;
  assign accept      = in_valid && !in_stall;
  assign ch_in_range = 32'(in_channel) < CHANNELS;
  assign ch_idx      = CH_W'(in_channel);
  assign ch_on       = ch_in_range && mask_r[ch_idx];
  assign cur_on      = mask_r[cur_r];

  // Rotating find-first: the nearest enabled channel after the pointer wins.
  always_comb begin
    cand      = '0;
    next_chan = cur_r;
    for (int k = CHANNELS; k >= 1; k--) begin
      cand = (CH_W+1)'(cur_r) + (CH_W+1)'(k);
      if (cand >= (CH_W+1)'(CHANNELS)) begin
        cand = cand - (CH_W+1)'(CHANNELS);
      end
      if (mask_r[cand[CH_W-1:0]]) begin
        next_chan = cand[CH_W-1:0];
      end
    end
  end

  always_comb begin
    mask_nxt   = mask_r;
    cur_nxt    = cur_r;
    valid_nxt  = valid_r && out_stall;
    result_nxt = result_r;
    mem_we     = 1'b0;
    mem_waddr  = ch_idx;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = ch_idx;
    if (accept) begin
      valid_nxt          = 1'b1;
      result_nxt.status  = ST_OK;
      result_nxt.read_ok = 1'b0;
      case (action_t'(in_action))
        ACT_SELECT: begin
          if (!ch_in_range) begin
            result_nxt.status = ST_NOT_SEL;
          end else if (ch_on) begin
            result_nxt.status = ST_BUSY;
          end else begin
            mask_nxt[ch_idx] = 1'b1;
            mem_we           = 1'b1;
          end
        end
        ACT_DESELECT: begin
          if (!ch_on) begin
            result_nxt.status = ST_NOT_SEL;
          end else begin
            mask_nxt[ch_idx] = 1'b0;
          end
        end
        ACT_SAMPLE: begin
          // Store for the channel on the mux if it is enabled, then move on.
          cur_nxt   = next_chan;
          mem_we    = cur_on;
          mem_waddr = cur_r;
          mem_wdata = in_sample;
        end
        ACT_READ: begin
          if (!ch_on) begin
            result_nxt.status = ST_NOT_SEL;
          end else begin
            result_nxt.read_ok = 1'b1;
            mem_re             = 1'b1;
          end
        end
        default: begin
          result_nxt.status = ST_NOT_SEL;
        end
      endcase
      result_nxt.adc_enable = |mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      cur_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      mask_r  <= mask_nxt;
      cur_r   <= cur_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_valid = valid_r;
  assign result    = result_r;
  assign cur_chan  = cur_r;

endmodule

// ----- hw/rtl/adc_mux_scan_sequencer.sv -----
// Round-robin ADC mux scan sequencer, top level.
// A result word is registered and appears in the cycle after its word is accepted.
// Throughput: one word per cycle; the input stalls only while a result is held
// by a stalled output, and the read value comes from the sample store's registered read port.
// Reset: synchronous, active low; clears the channel mask, mux pointer and
// output valid. Stored samples are not cleared; select zeroes an entry.
module adc_mux_scan_sequencer
  import amss_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [CHAN_W-1:0]   in_channel,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_adc_enable,
  output logic [CHAN_W-1:0]   out_mux_channel,
  output logic [SAMPLE_W-1:0] out_value
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  result_t             result;
  logic [CH_W-1:0]     cur_chan;
  logic                mem_we;
  logic [CH_W-1:0]     mem_waddr;
  logic [SAMPLE_W-1:0] mem_wdata;
  logic                mem_re;
  logic [CH_W-1:0]     mem_raddr;
  logic [SAMPLE_W-1:0] mem_rdata;

  amss_ctrl #(
    .CHANNELS (CHANNELS),
    .CH_W     (CH_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_action  (in_action),
    .in_channel (in_channel),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result),
    .cur_chan   (cur_chan),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr)
  );

  amss_store #(
    .DEPTH (CHANNELS),
    .AW    (CH_W),
    .DW    (SAMPLE_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_status      = result.status;
  assign out_adc_enable  = result.adc_enable;
  assign out_mux_channel = CHAN_W'(cur_chan);
  assign out_value       = result.read_ok ? mem_rdata : '0;

endmodule
